>>> src/image_border_color_stats_top_defines.svh
// Assertion macros for the border color statistics block
`ifndef IMAGE_BORDER_COLOR_STATS_TOP_DEFINES_SVH
`define IMAGE_BORDER_COLOR_STATS_TOP_DEFINES_SVH

// same-cycle implication
`define IBCS_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define IBCS_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> src/ibcs_pkg.sv
// Shared types, constants and helpers for the border color statistics block
`timescale 1ns / 1ps
package ibcs_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int XW          = 12;
  localparam int CW          = 13;
  localparam int SW          = 17;
  localparam int NW          = 10;
  localparam int BAND_DEPTH  = 8;
  localparam int STEP_SHIFT  = 5;
  localparam int QAW         = 2;
  localparam int QD          = 4;

  localparam logic [2:0] KIND_TOP    = 3'd0;
  localparam logic [2:0] KIND_BOTTOM = 3'd1;
  localparam logic [2:0] KIND_LEFT   = 3'd2;
  localparam logic [2:0] KIND_RIGHT  = 3'd3;
  localparam logic [2:0] KIND_BAND   = 3'd4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t            pix;
    logic [XW-1:0]   col;
    logic [XW-1:0]   row;
    logic [3:0]      emit;
    rgb_t [3:0]      strip;
    logic [3:0]      band;
    logic            fin;
  } job_t;

  // divide by 1, 2 or 3; the divide by 3 is a reciprocal multiply
  function automatic logic [7:0] div_small(input logic [9:0] s, input logic [1:0] n);
    logic [19:0] m;
    begin
      m = {10'd0, s} * 20'd683;
      case (n)
        2'd3:    div_small = m[18:11];
        2'd2:    div_small = s[8:1];
        default: div_small = s[7:0];
      endcase
    end
  endfunction

endpackage

>>> src/image_border_color_stats_top.sv
// Top level of the border color statistics block.
// Path: classify stage, request queue, result engine job register, output registers.
// Throughput: one pixel per cycle in the front end while the request queue is not full;
// the result engine takes a new pixel only once its strip results have left, and the last
// pixel of an image adds four band averages, each from the 17-step serial divider.
// Reset: synchronous, active low; size returns to 1x1, line memories not cleared.
`timescale 1ns / 1ps
`include "image_border_color_stats_top_defines.svh"
module image_border_color_stats_top import ibcs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [CW-1:0] cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_pix_red,
  input  logic [7:0]    in_pix_green,
  input  logic [7:0]    in_pix_blue,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_result_kind,
  output logic [XW-1:0] out_position,
  output logic [7:0]    out_avg_red,
  output logic [7:0]    out_avg_green,
  output logic [7:0]    out_avg_blue,
  output logic          out_last_of_item
);

  logic q_push, q_full, q_pop, q_empty, cfg_clr;
  job_t q_din, q_dout;

  assign cfg_clr = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  ibcs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pix_red   (in_pix_red),
    .in_pix_green (in_pix_green),
    .in_pix_blue  (in_pix_blue),
    .q_push       (q_push),
    .q_data       (q_din),
    .q_full       (q_full)
  );

  ibcs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  ibcs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_clr          (cfg_clr),
    .q_valid          (!q_empty),
    .q_data           (q_dout),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_position     (out_position),
    .out_avg_red      (out_avg_red),
    .out_avg_green    (out_avg_green),
    .out_avg_blue     (out_avg_blue),
    .out_last_of_item (out_last_of_item)
  );

  `IBCS_ASSERT_IMP(a_q_no_overflow, q_push, !q_full, "request queue overflow")
  `IBCS_ASSERT_IMP(a_q_no_underflow, q_pop, !q_empty, "request queue underflow")
  `IBCS_ASSERT_NXT(a_q_push_lands, q_push, !q_empty, "pushed request missing")
  `IBCS_ASSERT_IMP(a_band_pos, out_valid && out_result_kind == KIND_BAND, out_position < 12'd4, "band index out of range")

endmodule

>>> src/ibcs_front.sv
// Front end: size registers, raster position, line memories and strip averages
`timescale 1ns / 1ps
module ibcs_front import ibcs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [CW-1:0] cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_pix_red,
  input  logic [7:0]    in_pix_green,
  input  logic [7:0]    in_pix_blue,
  output logic          q_push,
  output job_t          q_data,
  input  logic          q_full
);

  typedef struct packed {
    logic       top;
    logic       top_first;
    logic       top_emit;
    logic       bot;
    logic       left;
    logic       left_first;
    logic       left_emit;
    logic       right;
    logic [3:0] band;
    logic       fin;
  } cls_t;

  logic [CW-1:0] width_r, height_r, w_eff, h_eff, bdw, bdh, w_lo, h_lo, wm1_full, hm1_full;
  logic [XW-1:0] wm1, hm1;
  logic [1:0]    nsw, nsh;
  logic [7:0]    sx, sy, sx_raw, sy_raw, cph_inc, rph_inc;
  logic [6:0]    cph_adv, rph_adv;
  logic          h_ge2;

  logic [XW-1:0] x_r, y_r;
  logic [6:0]    cph_r, rph_r;
  logic          accept, cfg_hit;
  cls_t          cls_a;

  logic          b_valid_r, b_adv, b_need;
  rgb_t          b_pix_r;
  logic [XW-1:0] b_x_r, b_y_r;
  cls_t          b_cls_r;

  logic [26:0]   top_mem [MAX_DIM];
  logic [23:0]   prev_mem [MAX_DIM];
  logic [26:0]   top_rd_r, fwd_top_d_r, top_wd;
  logic [23:0]   prev_rd_r, fwd_prev_d_r;
  logic          fwd_top_r, fwd_prev_r, top_we;

  logic [2:0][8:0] left_sum_r, top_src;
  logic [2:0][7:0] r0_r, r1_r, p, prev_src;
  logic [2:0][9:0] top_sum, left_sum, right_sum;
  logic [2:0][8:0] bot_sum;
  logic [2:0][7:0] top_avg, bot_avg, left_avg, right_avg;

  always_comb begin
    w_eff = width_r;
    if (width_r == '0) w_eff = CW'(1);
    else if (width_r > CW'(MAX_DIM)) w_eff = CW'(MAX_DIM);
    h_eff = height_r;
    if (height_r == '0) h_eff = CW'(1);
    else if (height_r > CW'(MAX_DIM)) h_eff = CW'(MAX_DIM);
  end

  assign wm1_full = w_eff - CW'(1);
  assign hm1_full = h_eff - CW'(1);
  assign wm1      = wm1_full[XW-1:0];
  assign hm1      = hm1_full[XW-1:0];
  assign nsw      = (w_eff >= CW'(3)) ? 2'd3 : w_eff[1:0];
  assign nsh      = (h_eff >= CW'(3)) ? 2'd3 : h_eff[1:0];
  assign h_ge2    = (h_eff >= CW'(2));
  assign bdw      = (w_eff >= CW'(BAND_DEPTH)) ? CW'(BAND_DEPTH) : w_eff;
  assign bdh      = (h_eff >= CW'(BAND_DEPTH)) ? CW'(BAND_DEPTH) : h_eff;
  assign w_lo     = w_eff - bdw;
  assign h_lo     = h_eff - bdh;
  assign sx_raw   = 8'(w_eff >> STEP_SHIFT);
  assign sy_raw   = 8'(h_eff >> STEP_SHIFT);
  assign sx       = (sx_raw == '0) ? 8'd1 : sx_raw;
  assign sy       = (sy_raw == '0) ? 8'd1 : sy_raw;
  assign cph_inc  = {1'b0, cph_r} + 8'd1;
  assign rph_inc  = {1'b0, rph_r} + 8'd1;
  assign cph_adv  = (cph_inc >= sx) ? 7'd0 : cph_inc[6:0];
  assign rph_adv  = (rph_inc >= sy) ? 7'd0 : rph_inc[6:0];

  assign cfg_hit  = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
  assign b_need   = b_cls_r.top_emit && b_cls_r.top || b_cls_r.bot
                    || b_cls_r.left && b_cls_r.left_emit || b_cls_r.right
                    || (|b_cls_r.band) || b_cls_r.fin;
  assign b_adv    = b_valid_r && !(b_need && q_full);
  assign in_stall = b_valid_r && b_need && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cls_a.top        = (y_r < {10'd0, nsh});
    cls_a.top_first  = (y_r == '0);
    cls_a.top_emit   = (y_r == {10'd0, nsh - 2'd1});
    cls_a.bot        = (y_r == hm1);
    cls_a.left       = (x_r < {10'd0, nsw});
    cls_a.left_first = (x_r == '0);
    cls_a.left_emit  = (x_r == {10'd0, nsw - 2'd1});
    cls_a.right      = (x_r == wm1);
    cls_a.band[0]    = (cph_r == '0) && ({1'b0, y_r} < bdh);
    cls_a.band[1]    = (cph_r == '0) && ({1'b0, y_r} >= h_lo);
    cls_a.band[2]    = (rph_r == '0) && ({1'b0, x_r} < bdw);
    cls_a.band[3]    = (rph_r == '0) && ({1'b0, x_r} >= w_lo);
    cls_a.fin        = (x_r == wm1) && (y_r == hm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= CW'(1);
      height_r  <= CW'(1);
      x_r       <= '0;
      y_r       <= '0;
      cph_r     <= '0;
      rph_r     <= '0;
      b_valid_r <= 1'b0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_WIDTH) width_r <= cfg_data;
      else height_r <= cfg_data;
      x_r       <= '0;
      y_r       <= '0;
      cph_r     <= '0;
      rph_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        b_valid_r <= 1'b1;
        if (x_r == wm1) begin
          x_r   <= '0;
          cph_r <= '0;
          if (y_r == hm1) begin
            y_r   <= '0;
            rph_r <= '0;
          end else begin
            y_r   <= y_r + XW'(1);
            rph_r <= rph_adv;
          end
        end else begin
          x_r   <= x_r + XW'(1);
          cph_r <= cph_adv;
        end
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  // classify stage: the line memory read lands here
  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix_r      <= '{red: in_pix_red, green: in_pix_green, blue: in_pix_blue};
      b_x_r        <= x_r;
      b_y_r        <= y_r;
      b_cls_r      <= cls_a;
      fwd_top_r    <= top_we && (b_x_r == x_r);
      fwd_top_d_r  <= top_wd;
      fwd_prev_r   <= b_adv && (b_x_r == x_r);
      fwd_prev_d_r <= b_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (top_we) top_mem[b_x_r] <= top_wd;
    if (accept) top_rd_r <= top_mem[x_r];
  end

  always_ff @(posedge clk) begin
    if (b_adv) prev_mem[b_x_r] <= b_pix_r;
    if (accept) prev_rd_r <= prev_mem[x_r];
  end

  assign p        = b_pix_r;
  assign top_src  = fwd_top_r ? fwd_top_d_r : top_rd_r;
  assign prev_src = fwd_prev_r ? fwd_prev_d_r : prev_rd_r;
  assign top_we   = b_adv && b_cls_r.top && !b_cls_r.top_emit;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      top_sum[c]   = (b_cls_r.top_first ? 10'd0 : {1'b0, top_src[c]}) + {2'd0, p[c]};
      top_avg[c]   = div_small(top_sum[c], nsh);
      top_wd[c*9 +: 9] = top_sum[c][8:0];
      bot_sum[c]   = {1'b0, p[c]} + {1'b0, prev_src[c]};
      bot_avg[c]   = h_ge2 ? bot_sum[c][8:1] : p[c];
      left_sum[c]  = (b_cls_r.left_first ? 10'd0 : {1'b0, left_sum_r[c]}) + {2'd0, p[c]};
      left_avg[c]  = div_small(left_sum[c], nsw);
      right_sum[c] = {2'd0, p[c]} + ((nsw >= 2'd2) ? {2'd0, r0_r[c]} : 10'd0)
                     + ((nsw == 2'd3) ? {2'd0, r1_r[c]} : 10'd0);
      right_avg[c] = div_small(right_sum[c], nsw);
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      if (b_cls_r.left && !b_cls_r.left_emit) begin
        for (int c = 0; c < 3; c++) left_sum_r[c] <= left_sum[c][8:0];
      end
      r1_r <= r0_r;
      r0_r <= p;
    end
  end

  assign q_push        = b_adv && b_need;
  assign q_data.pix    = b_pix_r;
  assign q_data.col    = b_x_r;
  assign q_data.row    = b_y_r;
  assign q_data.emit   = {b_cls_r.right, b_cls_r.left && b_cls_r.left_emit,
                          b_cls_r.bot, b_cls_r.top && b_cls_r.top_emit};
  assign q_data.strip  = {rgb_t'(right_avg), rgb_t'(left_avg),
                          rgb_t'(bot_avg), rgb_t'(top_avg)};
  assign q_data.band   = b_cls_r.band;
  assign q_data.fin    = b_cls_r.fin;

endmodule

>>> src/ibcs_queue.sv
// Request queue between front end and result engine
`timescale 1ns / 1ps
module ibcs_queue import ibcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t           mem [QD];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QD));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QAW'(1);
      if (pop) rd_r <= rd_r + QAW'(1);
      if (push && !pop) cnt_r <= cnt_r + (QAW+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (QAW+1)'(1);
    end
  end

endmodule

>>> src/ibcs_div.sv
// Bit-serial restoring divider, three color channels sharing one divisor
`timescale 1ns / 1ps
module ibcs_div import ibcs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0][SW-1:0]  dvd,
  input  logic [NW-1:0]       dvs,
  output logic                busy,
  output logic [2:0][7:0]     quo
);

  logic              busy_r;
  logic [4:0]        cnt_r;
  logic [NW-1:0]     dvs_r;
  logic [2:0][SW-1:0] dq_r;
  logic [2:0][NW-1:0] rem_r, rem_nxt;
  logic [2:0][NW:0]   t;
  logic [2:0]         ge;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t[c]       = {rem_r[c], dq_r[c][SW-1]};
      ge[c]      = (t[c] >= {1'b0, dvs_r});
      rem_nxt[c] = ge[c] ? NW'(t[c] - {1'b0, dvs_r}) : t[c][NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(SW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dvd;
      rem_r <= '0;
      dvs_r <= dvs;
    end else if (busy_r) begin
      for (int c = 0; c < 3; c++) begin
        dq_r[c]  <= {dq_r[c][SW-2:0], ge[c]};
        rem_r[c] <= rem_nxt[c];
      end
    end
  end

  assign busy = busy_r;
  always_comb begin
    for (int c = 0; c < 3; c++) quo[c] = dq_r[c][7:0];
  end

endmodule

>>> src/ibcs_back.sv
// Result engine: band accumulators, strip result emission and band averages
`timescale 1ns / 1ps
module ibcs_back import ibcs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_clr,
  input  logic          q_valid,
  input  job_t          q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_result_kind,
  output logic [XW-1:0] out_position,
  output logic [7:0]    out_avg_red,
  output logic [7:0]    out_avg_green,
  output logic [7:0]    out_avg_blue,
  output logic          out_last_of_item
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STRIP = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_BAND  = 3'd4;

  logic [2:0]  st_r, st_nxt;
  job_t        job_r;
  logic [3:0]  pend_r, pend_nxt;
  logic [1:0]  band_r, band_nxt, sel;
  logic [2:0][SW-1:0] sum_r [4];
  logic [NW-1:0]      cnt_r [4];
  logic [2:0][7:0]    pix, quo;
  logic        acc_en, clr, emit, e_last, out_free, div_start, div_busy;
  logic [2:0]  e_kind;
  logic [XW-1:0] e_pos;
  rgb_t        e_rgb;
  logic        out_valid_r;

  assign out_free = !out_valid_r || !out_stall;
  assign pix      = q_data.pix;

  ibcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (sum_r[band_r]),
    .dvs   (cnt_r[band_r]),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_comb begin
    sel = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (pend_r[k]) sel = 2'(k);
    end
  end

  always_comb begin
    st_nxt    = st_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    e_kind    = KIND_TOP;
    e_pos     = '0;
    e_rgb     = '0;
    e_last    = 1'b0;
    pend_nxt  = pend_r;
    band_nxt  = band_r;
    acc_en    = 1'b0;
    clr       = cfg_clr;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          acc_en   = 1'b1;
          pend_nxt = q_data.emit;
          band_nxt = 2'd0;
          if (|q_data.emit) st_nxt = S_STRIP;
          else if (q_data.fin) st_nxt = S_START;
        end
      end
      S_STRIP: begin
        if (out_free) begin
          emit     = 1'b1;
          case (sel)
            2'd0:    e_kind = KIND_TOP;
            2'd1:    e_kind = KIND_BOTTOM;
            2'd2:    e_kind = KIND_LEFT;
            default: e_kind = KIND_RIGHT;
          endcase
          e_pos    = sel[1] ? job_r.row : job_r.col;
          e_rgb    = job_r.strip[sel];
          pend_nxt = pend_r & ~(4'd1 << sel);
          e_last   = (pend_nxt == '0) && !job_r.fin;
          if (pend_nxt == '0) st_nxt = job_r.fin ? S_START : S_IDLE;
        end
      end
      S_START: begin
        div_start = 1'b1;
        st_nxt    = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) st_nxt = S_BAND;
      end
      S_BAND: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = KIND_BAND;
          e_pos  = {10'd0, band_r};
          e_rgb  = (cnt_r[band_r] == '0) ? '0 : rgb_t'(quo);
          e_last = (band_r == 2'd3);
          if (band_r == 2'd3) begin
            clr    = 1'b1;
            st_nxt = S_IDLE;
          end else begin
            band_nxt = band_r + 2'd1;
            st_nxt   = S_START;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pend_r      <= '0;
      band_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= '0;
        cnt_r[k] <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      pend_r <= pend_nxt;
      band_r <= band_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (clr) begin
        for (int k = 0; k < 4; k++) begin
          sum_r[k] <= '0;
          cnt_r[k] <= '0;
        end
      end else if (acc_en) begin
        for (int k = 0; k < 4; k++) begin
          if (q_data.band[k]) begin
            for (int c = 0; c < 3; c++) sum_r[k][c] <= sum_r[k][c] + {9'd0, pix[c]};
            cnt_r[k] <= cnt_r[k] + NW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_data;
    if (emit) begin
      out_result_kind  <= e_kind;
      out_position     <= e_pos;
      out_avg_red      <= e_rgb.red;
      out_avg_green    <= e_rgb.green;
      out_avg_blue     <= e_rgb.blue;
      out_last_of_item <= e_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> test/tb.sv
// Self-checking testbench for the image border color statistics block
`timescale 1ns / 1ps
module tb;
  import ibcs_pkg::*;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int LIMIT = 1500000;

  typedef struct {
    logic [2:0]    kind;
    logic [XW-1:0] pos;
    rgb_t          avg;
    logic          last;
  } border_avg_t;

  class border_stats_board;
    logic [CW-1:0] width_reg, height_reg;
    int unsigned col, row, col_phase, row_phase;
    int unsigned top_sum[MAX_DIM][3];
    int unsigned prev_pix[MAX_DIM][3];
    int unsigned left_sum[3];
    int unsigned recent[2][3];
    longint unsigned band_sum[4][3];
    int unsigned band_cnt[4];
    border_avg_t pending_avgs[$];
    int errors, checked;

    function new();
      width_reg = 1;
      height_reg = 1;
      errors = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      col = 0; row = 0; col_phase = 0; row_phase = 0;
      for (int c = 0; c < 3; c++) begin
        left_sum[c] = 0; recent[0][c] = 0; recent[1][c] = 0;
        for (int k = 0; k < 4; k++) band_sum[k][c] = 0;
      end
      for (int k = 0; k < 4; k++) band_cnt[k] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CW-1:0] val);
      if (idx == REG_WIDTH) width_reg = val;
      else if (idx == REG_HEIGHT) height_reg = val;
      else return;
      restart();
    endfunction

    function void push(logic [2:0] kind, int unsigned pos, int unsigned r, int unsigned g,
                       int unsigned b);
      border_avg_t e;
      e.kind = kind;
      e.pos = pos[XW-1:0];
      e.avg = '{red: r[7:0], green: g[7:0], blue: b[7:0]};
      e.last = 0;
      pending_avgs.insert(pending_avgs.size(), e);
    endfunction

    function void note_pixel(rgb_t px);
      int unsigned w, h, x, y, nsh, nsw, bdh, bdw, sx, sy, n0;
      int unsigned p[3], s[3];
      w = width_reg == 0 ? 1 : (width_reg > MAX_DIM ? MAX_DIM : width_reg);
      h = height_reg == 0 ? 1 : (height_reg > MAX_DIM ? MAX_DIM : height_reg);
      x = col; y = row;
      nsh = h < 3 ? h : 3;
      nsw = w < 3 ? w : 3;
      bdh = h < BAND_DEPTH ? h : BAND_DEPTH;
      bdw = w < BAND_DEPTH ? w : BAND_DEPTH;
      sx = w / 32; sy = h / 32;
      if (sx == 0) sx = 1;
      if (sy == 0) sy = 1;
      n0 = pending_avgs.size();
      p[0] = px.red; p[1] = px.green; p[2] = px.blue;
      if (y < nsh) begin
        for (int c = 0; c < 3; c++) s[c] = (y == 0 ? 0 : top_sum[x][c]) + p[c];
        if (y == nsh - 1) push(KIND_TOP, x, s[0] / nsh, s[1] / nsh, s[2] / nsh);
        else for (int c = 0; c < 3; c++) top_sum[x][c] = s[c];
      end
      if (y == h - 1) begin
        if (h >= 2) begin
          for (int c = 0; c < 3; c++) s[c] = (p[c] + prev_pix[x][c]) / 2;
          push(KIND_BOTTOM, x, s[0], s[1], s[2]);
        end else push(KIND_BOTTOM, x, p[0], p[1], p[2]);
      end
      if (x < nsw) begin
        for (int c = 0; c < 3; c++) s[c] = (x == 0 ? 0 : left_sum[c]) + p[c];
        if (x == nsw - 1) push(KIND_LEFT, y, s[0] / nsw, s[1] / nsw, s[2] / nsw);
        else for (int c = 0; c < 3; c++) left_sum[c] = s[c];
      end
      if (x == w - 1) begin
        for (int c = 0; c < 3; c++) begin
          s[c] = p[c];
          if (nsw >= 2) s[c] += recent[0][c];
          if (nsw >= 3) s[c] += recent[1][c];
          s[c] /= nsw;
        end
        push(KIND_RIGHT, y, s[0], s[1], s[2]);
      end
      if (col_phase == 0) begin
        if (y < bdh) add_band(0, p);
        if (y >= h - bdh) add_band(1, p);
      end
      if (row_phase == 0) begin
        if (x < bdw) add_band(2, p);
        if (x >= w - bdw) add_band(3, p);
      end
      for (int c = 0; c < 3; c++) begin
        prev_pix[x][c] = p[c];
        recent[1][c] = recent[0][c];
        recent[0][c] = p[c];
      end
      if (x == w - 1) begin
        col = 0;
        col_phase = 0;
        if (y == h - 1) begin
          for (int k = 0; k < 4; k++) begin
            if (band_cnt[k] == 0) push(KIND_BAND, k, 0, 0, 0);
            else push(KIND_BAND, k, 32'(band_sum[k][0] / band_cnt[k]),
                      32'(band_sum[k][1] / band_cnt[k]), 32'(band_sum[k][2] / band_cnt[k]));
          end
          restart();
        end else begin
          row = y + 1;
          row_phase = (row_phase + 1 >= sy) ? 0 : row_phase + 1;
        end
      end else begin
        col = x + 1;
        col_phase = (col_phase + 1 >= sx) ? 0 : col_phase + 1;
      end
      if (pending_avgs.size() > n0) pending_avgs[pending_avgs.size() - 1].last = 1;
    endfunction

    function void add_band(int k, int unsigned p[3]);
      for (int c = 0; c < 3; c++) band_sum[k][c] += p[c];
      band_cnt[k]++;
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [2:0] kind, logic [XW-1:0] pos, rgb_t avg, logic last);
      border_avg_t e;
      checked++;
      if (pending_avgs.size() == 0) begin
        report($sformatf("unexpected result kind %0d pos %0d", kind, pos));
        return;
      end
      e = pending_avgs.pop_front();
      if (kind !== e.kind || pos !== e.pos || avg !== e.avg || last !== e.last)
        report($sformatf("got k%0d p%0d %h l%0b, want k%0d p%0d %h l%0b",
                         kind, pos, avg, last, e.kind, e.pos, e.avg, e.last));
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_wr_en = 0;
  logic [1:0] cfg_index = 0;
  logic [CW-1:0] cfg_data = 0;
  logic in_valid = 0, in_stall;
  logic [7:0] in_pix_red = 0, in_pix_green = 0, in_pix_blue = 0;
  logic out_valid, out_stall = 0, out_last_of_item;
  logic [2:0] out_result_kind;
  logic [XW-1:0] out_position;
  logic [7:0] out_avg_red, out_avg_green, out_avg_blue;

  border_stats_board board = new();
  int idle_pct = 0, stall_pct = 0, pixels = 0, images = 0, hold_left = 0;
  logic hold_go = 0;
  int unsigned cycles = 0;

  image_border_color_stats_top i_dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("image_border_color_stats_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_result_kind, out_position,
                         '{red: out_avg_red, green: out_avg_green, blue: out_avg_blue},
                         out_last_of_item);
    if (hold_go && hold_left == 0) begin
      hold_left <= 400;
      out_stall <= 1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      hold_left <= 0;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_pix_red <= r;
    in_pix_green <= g;
    in_pix_blue <= b;
    do @(posedge clk); while (in_stall);
    board.note_pixel('{red: r, green: g, blue: b});
    pixels++;
  endtask

  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending_avgs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [CW-1:0] val);
    drain();
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_wr_en <= 0;
  endtask

  task set_size(int w, int h);
    write_reg(REG_WIDTH, CW'(w));
    write_reg(REG_HEIGHT, CW'(h));
  endtask

  function logic [7:0] rand_chan();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task send_image(int n);
    for (int i = 0; i < n; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());
    images++;
  endtask

  task set_mode(int m);
    case (m % 4)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 53; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 53; end
      default: begin idle_pct = 21; stall_pct = 21; end
    endcase
  endtask

  initial begin
    int w, h, start;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // 1x1 after reset: every pixel closes an image
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'haa, 8'h55, 8'h0f);
    write_reg(REG_SPARE_A, 13'h1fff);
    write_reg(REG_SPARE_B, 13'h0005);
    send_pixel(8'h55, 8'haa, 8'hf0);
    set_size(0, 0);
    send_image(2);
    set_size(3, 3);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_image(6);
    set_size(2, 2);
    send_image(4);
    // register write mid-image restarts the frame
    set_size(4, 3);
    send_image(5);
    write_reg(REG_HEIGHT, CW'(2));
    send_image(8);

    start = pixels;
    while (pixels - start < 180) begin
      set_mode(images);
      case ($urandom_range(9))
        0: begin w = $urandom_range(33, 80); h = $urandom_range(1, 3); end
        1: begin w = $urandom_range(1, 2); h = $urandom_range(33, 70); end
        default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 12); end
      endcase
      set_size(w, h);
      if ($urandom_range(7) == 0) begin
        send_image($urandom_range(1, w * h));
        write_reg(REG_WIDTH, CW'(w));
      end
      send_image(w * h);
    end

    // long receiver hold while the sender keeps pushing
    set_mode(0);
    set_size(10, 10);
    hold_go <= 1;
    @(posedge clk);
    hold_go <= 0;
    send_image(100);

    // size extremes, partial frames; oversize values clamp to the maximum
    set_mode(3);
    set_size(13'h1fff, 1);
    send_image(40);
    set_size(1, MAX_DIM);
    send_image(40);
    set_size(MAX_DIM, 2);
    send_image(40);

    drain();
    if (board.pending_avgs.size() != 0) board.report("results still outstanding");
    $display("Covered %0d pixels over %0d images, %0d results checked,", pixels, images,
             board.checked);
    $display("with sizes from 1x1 to partial frames at the 4096 limit, restarts and stalls.");
    if (board.errors == 0) $display("image_border_color_stats_top verification clean");
    else $display("image_border_color_stats_top verification failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/ibcs_pkg.sv
src/ibcs_front.sv
src/ibcs_queue.sv
src/ibcs_div.sv
src/ibcs_back.sv
src/image_border_color_stats_top.sv
test/tb.sv
